// ===== rtl/core/id_pool_allocator_core_assert.svh =====
// Assertion macros used by the allocator top level.
`ifndef ID_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define ID_POOL_ALLOCATOR_CORE_ASSERT_SVH

// Implication within the same cycle.
`define IDPA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication into the next cycle.
`define IDPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/idpa_pkg.sv =====
// Package: constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package idpa_pkg;
  localparam int POOL_SIZE = 64;
  localparam int OFF_W     = 6;
  localparam int CNT_W     = 7;
  localparam int GID_W     = 32;
  localparam int MASK_W    = 64;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_TEST  = 1'b1
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_GID   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_COUNT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_A_RD,
    S_A_PR,
    S_B_RD,
    S_B_PR,
    S_P_RD,
    S_P_WR,
    S_T_RD,
    S_T_EV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic a_rd;
    logic a_pr;
    logic b_rd;
    logic b_pr;
    logic p_rd;
    logic p_wr;
    logic t_rd;
    logic t_ev;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic             is_test;
    logic             last;
    logic             free_empty;
    logic             used_empty;
    logic             a_last;
    logic             b_last;
    logic             out_free;
    logic [CNT_W-1:0] free_depth;
    logic [CNT_W-1:0] used_depth;
    logic [CNT_W-1:0] pool_n;
  } sts_t;
endpackage

// ===== rtl/core/idpa_ctrl.sv =====
// Controller state machine for the ID pool allocator.
`timescale 1ns / 1ps
module idpa_ctrl
  import idpa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  sts_t sts,
  output logic idle,
  output cmd_t cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_CHK;
      S_CHK: begin
        if (sts.is_test) state_nxt = S_T_RD;
        else if (!sts.free_empty) state_nxt = S_P_RD;
        else if (!sts.used_empty) state_nxt = S_A_RD;
        else state_nxt = S_OUT;
      end
      S_A_RD: state_nxt = S_A_PR;
      S_A_PR: state_nxt = sts.a_last ? S_B_RD : S_A_RD;
      S_B_RD: state_nxt = S_B_PR;
      S_B_PR: begin
        if (!sts.b_last) state_nxt = S_B_RD;
        else if (!sts.free_empty) state_nxt = S_P_RD;
        else state_nxt = S_OUT;
      end
      S_P_RD: state_nxt = S_P_WR;
      S_P_WR: state_nxt = S_OUT;
      S_T_RD: state_nxt = S_T_EV;
      S_T_EV: state_nxt = sts.last ? S_OUT : S_IDLE;
      S_OUT:  if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    idle     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        idle     = 1'b1;
        cmd.load = in_fire;
      end
      S_CHK:  ;
      S_A_RD: cmd.a_rd = 1'b1;
      S_A_PR: cmd.a_pr = 1'b1;
      S_B_RD: cmd.b_rd = 1'b1;
      S_B_PR: cmd.b_pr = 1'b1;
      S_P_RD: cmd.p_rd = 1'b1;
      S_P_WR: cmd.p_wr = 1'b1;
      S_T_RD: cmd.t_rd = 1'b1;
      S_T_EV: cmd.t_ev = 1'b1;
      S_OUT:  cmd.out_load = sts.out_free;
      default: ;
    endcase
  end
endmodule

// ===== rtl/core/idpa_dp.sv =====
// Datapath: free stack, used list, owner table, counters and result register.
`timescale 1ns / 1ps
module idpa_dp
  import idpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_op,
  input  logic                  in_last,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  out_tready,
  output logic                  out_valid,
  output logic                  out_kind,
  output logic [OUT_DATA_W-1:0] out_data,
  output sts_t                  sts
);
  logic [OFF_W-1:0] free_mem  [POOL_SIZE];
  logic [OFF_W-1:0] used_mem  [POOL_SIZE];
  logic [GID_W-1:0] owner_mem [POOL_SIZE];

  logic [GID_W-1:0]     base_r;
  logic [CNT_W-1:0]     pool_n_r;
  logic [CNT_W-1:0]     free_depth_r, used_depth_r, hi_r, idx_r, kept_r;
  logic [POOL_SIZE-1:0] used_flag_r;
  logic                 match_seen_r;
  logic                 out_valid_r, out_kind_r, out_match_r;
  logic [GID_W-1:0]     out_gid_r;

  logic                 op_r, last_r, tvalid_r;
  logic [GID_W-1:0]     owner_r, query_r, owner_rd_r;
  logic [MASK_W-1:0]    mask_r;
  logic [OFF_W-1:0]     used_rd_r, free_rd_r;
  logic [GID_W-1:0]     res_gid_r;
  logic                 res_match_r;

  logic [CNT_W-1:0] idx_m1, fidx, init_val, sat_n, new_n;
  logic [OFF_W-1:0] pop_off;
  logic [GID_W-1:0] diff;
  logic             hit, keep;

  assign idx_m1   = idx_r - 7'd1;
  assign fidx     = free_depth_r - 7'd1;
  assign init_val = pool_n_r - 7'd1 - fidx;
  assign pop_off  = (fidx < hi_r) ? free_rd_r : init_val[OFF_W-1:0];
  assign diff     = query_r - base_r;
  assign hit      = tvalid_r && (owner_rd_r == owner_r);
  assign keep     = mask_r[used_rd_r];
  assign sat_n    = (cfg_wdata[CNT_W-1:0] > CNT_W'(POOL_SIZE)) ? CNT_W'(POOL_SIZE)
                                                            : cfg_wdata[CNT_W-1:0];
  assign new_n    = (cfg_index == REG_POOL_COUNT) ? sat_n : pool_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= '0;
      pool_n_r     <= '0;
      free_depth_r <= '0;
      used_depth_r <= '0;
      hi_r         <= '0;
      used_flag_r  <= '0;
      match_seen_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_BASE_GID) base_r <= cfg_wdata[GID_W-1:0];
      pool_n_r     <= new_n;
      free_depth_r <= new_n;
      used_depth_r <= '0;
      hi_r         <= '0;
      used_flag_r  <= '0;
      match_seen_r <= 1'b0;
    end else begin
      if (cmd.a_pr && !keep) begin
        free_depth_r       <= free_depth_r + 7'd1;
        used_flag_r[used_rd_r] <= 1'b0;
        if (free_depth_r + 7'd1 > hi_r) hi_r <= free_depth_r + 7'd1;
      end
      if (cmd.b_pr && sts.b_last) used_depth_r <= kept_r + {6'd0, keep};
      if (cmd.p_wr) begin
        free_depth_r         <= fidx;
        used_depth_r         <= used_depth_r + 7'd1;
        used_flag_r[pop_off] <= 1'b1;
      end
      if (cmd.t_ev) match_seen_r <= last_r ? 1'b0 : (match_seen_r | hit);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= in_op;
      last_r      <= in_last;
      owner_r     <= in_data[31:0];
      query_r     <= in_data[63:32];
      mask_r      <= in_data[127:64];
      idx_r       <= used_depth_r;
      res_gid_r   <= '0;
      res_match_r <= 1'b0;
    end
    if (cmd.a_rd) used_rd_r <= used_mem[idx_m1[OFF_W-1:0]];
    if (cmd.a_pr) begin
      if (!keep) free_mem[free_depth_r[OFF_W-1:0]] <= used_rd_r;
      if (sts.a_last) begin
        idx_r  <= '0;
        kept_r <= '0;
      end else begin
        idx_r <= idx_m1;
      end
    end
    if (cmd.b_rd) used_rd_r <= used_mem[idx_r[OFF_W-1:0]];
    if (cmd.b_pr) begin
      if (keep) begin
        used_mem[kept_r[OFF_W-1:0]] <= used_rd_r;
        kept_r <= kept_r + 7'd1;
      end
      idx_r <= idx_r + 7'd1;
    end
    if (cmd.p_rd) free_rd_r <= free_mem[fidx[OFF_W-1:0]];
    if (cmd.p_wr) begin
      owner_mem[pop_off]                     <= owner_r;
      used_mem[used_depth_r[OFF_W-1:0]]      <= pop_off;
      res_gid_r                              <= base_r + {26'd0, pop_off};
    end
    if (cmd.t_rd) begin
      tvalid_r   <= (diff < {25'd0, pool_n_r}) && used_flag_r[diff[OFF_W-1:0]];
      owner_rd_r <= owner_mem[diff[OFF_W-1:0]];
    end
    if (cmd.t_ev) res_match_r <= match_seen_r | hit;
    if (cmd.out_load) begin
      out_kind_r  <= op_r;
      out_gid_r   <= res_gid_r;
      out_match_r <= res_match_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_data  = {7'd0, out_match_r, out_gid_r};

  always_comb begin
    sts            = '0;
    sts.is_test    = (op_r == OP_TEST);
    sts.last       = last_r;
    sts.free_empty = (free_depth_r == '0);
    sts.used_empty = (used_depth_r == '0);
    sts.a_last     = (idx_r == 7'd1);
    sts.b_last     = (idx_r == used_depth_r - 7'd1);
    sts.out_free   = !out_valid_r || out_tready;
    sts.free_depth = free_depth_r;
    sts.used_depth = used_depth_r;
    sts.pool_n     = pool_n_r;
  end
endmodule

// ===== rtl/core/id_pool_allocator_core.sv =====
// Group ID pool allocator: top level.
// Usage:
//  - Program base_gid (index 0) and pool_count (index 1) on the cfg port while
//    idle; every write reinitializes the pool (all IDs free, lowest on top).
//  - Input transactions: in_tuser is the operation (0 allocate, 1 test),
//    in_tlast marks the last test item of a set.
//  - An allocation returns one transaction (out_tuser 0) with the granted ID,
//    or 0 when the pool is exhausted. A test item returns nothing unless it is
//    the last of a set, which returns out_tuser 1 with the owner match flag.
//  - Flow: out_tvalid is registered on leaving S_OUT; an allocation with a free ID
//    passes S_CHK, S_P_RD, S_P_WR and S_OUT, the last test item S_CHK, S_T_RD,
//    S_T_EV and S_OUT. With an empty free stack, the reclaim walk over the used
//    list comes first (two passes, a read and a process state per entry over the
//    registered list memory).
//  - One item is processed at a time; in_tready is high when the controller
//    is idle, so a new item is accepted only after the last one is finished.
//  - The output register holds a result while out_tready is low; the next
//    item is still accepted and processed, and waits only to load its result.
//  - Reset (rst_n low, synchronous) clears the configuration, counters, flags and out_tvalid to zero: empty pool.
`timescale 1ns / 1ps
`include "id_pool_allocator_core_assert.svh"
module id_pool_allocator_core
  import idpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // owner_id, query_gid, in_use_mask
  input  logic                  in_tuser,   // operation
  input  logic                  in_tlast,   // last_in_set
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // granted_gid, owner_match, zero pad
  output logic                  out_tuser   // result_kind
);
  cmd_t cmd;
  sts_t sts;
  logic idle;

  idpa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_tvalid && in_tready),
    .sts     (sts),
    .idle    (idle),
    .cmd     (cmd)
  );

  idpa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_op      (in_tuser),
    .in_last    (in_tlast),
    .in_data    (in_tdata),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_kind   (out_tuser),
    .out_data   (out_tdata),
    .sts        (sts)
  );

  assign in_tready = idle;

  `IDPA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `IDPA_ASSERT_IMPL(a_pool_conserved, clk, rst_n, idle && !cfg_we,
    ({1'b0, sts.free_depth} + {1'b0, sts.used_depth}) <= {1'b0, sts.pool_n})
  `IDPA_ASSERT_IMPL(a_no_load_when_busy, clk, rst_n, cmd.load, in_tvalid && idle)
endmodule

// ===== tb/tb.sv =====
// Testbench for the group ID pool allocator: scoreboard-checked random and directed traffic.
`timescale 1ns / 1ps
module tb;
  import idpa_pkg::*;

  class gid_scoreboard;
    logic [31:0] base;
    logic [6:0] count;
    logic [5:0] free_stk[64];
    int free_n;
    logic [5:0] used_list[64];
    int used_n;
    logic [31:0] owner_of[64];
    bit seen;
    logic [32:0] pending[$];
    int errors;

    function void init();
      int n;
      n = (count > 64) ? 64 : count;
      for (int i = 0; i < n; i++) free_stk[i] = 6'(n - 1 - i);
      free_n = n;
      used_n = 0;
      for (int i = 0; i < 64; i++) begin
        owner_of[i] = 0;
        used_list[i] = 0;
      end
      seen = 0;
    endfunction

    function void note_input(op_t op, logic [31:0] owner, logic [31:0] query,
                             logic [63:0] mask, logic last);
      logic [5:0] kept[64];
      int nk;
      logic [5:0] off;
      logic [31:0] gid;
      bit hit;
      if (op == OP_ALLOC) begin
        gid = 0;
        if (free_n == 0) begin
          nk = 0;
          for (int i = used_n - 1; i >= 0; i--) begin
            off = used_list[i];
            if (!mask[off]) begin
              if (free_n < 64) begin
                free_stk[free_n] = off;
                free_n++;
              end
            end else begin
              kept[nk] = off;
              nk++;
            end
          end
          used_n = nk;
          for (int i = 0; i < nk; i++) used_list[nk - 1 - i] = kept[i];
        end
        if (free_n > 0) begin
          free_n--;
          off = free_stk[free_n];
          owner_of[off] = owner;
          if (used_n < 64) begin
            used_list[used_n] = off;
            used_n++;
          end
          gid = base + 32'(off);
        end
        pending.push_back({1'b0, gid});
      end else begin
        hit = 0;
        for (int i = 0; i < used_n; i++) begin
          off = used_list[i];
          if (base + 32'(off) == query && owner_of[off] == owner) hit = 1;
        end
        if (hit) seen = 1;
        if (last) begin
          pending.push_back({1'b1, 31'b0, seen});
          seen = 0;
        end
      end
    endfunction

    function void check_result(logic kind, logic [31:0] gid, logic match);
      logic [32:0] e;
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d gid=%0h match=%0d", kind, gid, match);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (kind !== e[32]) begin
        $error("result_kind expected %0d actual %0d", e[32], kind);
        errors++;
      end
      if (e[32] == 1'b0 && gid !== e[31:0]) begin
        $error("granted_gid expected %0h actual %0h", e[31:0], gid);
        errors++;
      end
      if (e[32] == 1'b0 && match !== 1'b0) begin
        $error("owner_match expected 0 actual %0d", match);
        errors++;
      end
      if (e[32] == 1'b1 && match !== e[0]) begin
        $error("owner_match expected %0d actual %0d", e[0], match);
        errors++;
      end
      if (e[32] == 1'b1 && gid !== 32'b0) begin
        $error("granted_gid expected 0 actual %0h", gid);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;

  gid_scoreboard sb;
  bit calm = 0;
  bit long_hold = 0;
  int hold_cycles = 0;
  logic [31:0] owners[4];

  always #2 clk = ~clk;

  id_pool_allocator_core u_top (.*);

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_result(out_tuser, out_tdata[31:0], out_tdata[32]);
      if (long_hold) begin
        long_hold <= 0;
        hold_cycles <= 300;
        out_tready <= 0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold_cycles <= $urandom_range(0, 3);
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_BASE_GID) sb.base = val;
    else sb.count = val[6:0];
    sb.init();
    @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    in_tvalid <= 0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (600) @(posedge clk);
  endtask

  task automatic send(op_t op, logic [31:0] owner, logic [31:0] query,
                      logic [63:0] mask, logic last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tlast <= last;
    in_tdata <= {mask, query, owner};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, owner, query, mask, last);
  endtask

  function automatic logic [63:0] rand_mask();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_item(int sz);
    logic [31:0] q;
    int n;
    if ($urandom_range(0, 9) < 6) begin
      send(OP_ALLOC, owners[$urandom_range(0, 3)], $urandom, rand_mask(), 1'($urandom));
    end else begin
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 5) == 0) q = $urandom;
        else q = sb.base + $urandom_range(0, sz);
        send(OP_TEST, owners[$urandom_range(0, 3)], q, rand_mask(), k == n - 1);
        if ($urandom_range(0, 7) == 0)
          send(OP_ALLOC, owners[$urandom_range(0, 3)], $urandom, rand_mask(), 1'b0);
      end
    end
  endtask

  initial begin
    int sz;
    sb = new();
    sb.base = 0;
    sb.count = 0;
    sb.init();
    sb.errors = 0;
    owners[0] = 0;
    owners[1] = 32'hFFFF_FFFF;
    owners[2] = $urandom;
    owners[3] = $urandom;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // empty pool after reset
    send(OP_ALLOC, 32'd1, 32'd0, '0, 1'b0);
    send(OP_TEST, 32'd1, 32'd0, '0, 1'b1);
    drain();
    write_reg(REG_BASE_GID, 32'hFFFF_FFFE);
    write_reg(REG_POOL_COUNT, 32'd3);
    send(OP_ALLOC, owners[1], 32'd0, '0, 1'b0);
    send(OP_ALLOC, owners[0], 32'd0, '0, 1'b0);
    send(OP_ALLOC, owners[1], 32'd0, '0, 1'b0);
    send(OP_ALLOC, owners[0], 32'd0, '1, 1'b0);
    send(OP_ALLOC, owners[0], 32'd0, 64'h2, 1'b0);
    send(OP_TEST, owners[1], 32'hFFFF_FFFE, '0, 1'b0);
    send(OP_TEST, owners[1], 32'h5, '0, 1'b1);
    send(OP_TEST, owners[0], 32'h1234, '0, 1'b0);
    send(OP_ALLOC, owners[0], 32'd0, '1, 1'b0);
    send(OP_TEST, owners[0], 32'hFFFF_FFFF, '0, 1'b1);
    send(OP_TEST, owners[1], 32'hFFFF_FFFF, '1, 1'b1);
    drain();
    write_reg(REG_POOL_COUNT, 32'd127);
    send(OP_ALLOC, owners[2], 32'd0, '0, 1'b0);
    send(OP_TEST, owners[2], 32'hFFFF_FFFE, '0, 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: sz = 0;
        1: sz = 1;
        2: sz = 64;
        3: sz = 2;
        default: sz = $urandom_range(2, 12);
      endcase
      write_reg(REG_BASE_GID, (ph == 2) ? 32'h0 : $urandom);
      write_reg(REG_POOL_COUNT, 32'(sz));
      if (ph == 7) calm = 1;
      for (int i = 0; i < ((sz == 64) ? 160 : 100); i++) begin
        if (ph == 3 && i == 20) long_hold = 1;
        if (ph == 4 && i == 30) drain();
        random_item(sz);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/idpa_pkg.sv
rtl/core/idpa_ctrl.sv
rtl/core/idpa_dp.sv
rtl/core/id_pool_allocator_core.sv
tb/tb.sv
